// ----- sv/psmi_pkg.sv -----
// ----------------------------------------------------------------------------
// psmi_pkg
// Shared widths, codes and controller/datapath interface types for the
// 3D point set moment invariants block.
// ----------------------------------------------------------------------------
`default_nettype none

package psmi_pkg;

   localparam int MAX_POINTS = 65536;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 16;
   localparam int S1_W       = 33;
   localparam int S2_W       = 48;
   localparam int NSQ_W      = 2 * CNT_W;
   localparam int ROOT_W     = 38;
   localparam int BIT_W      = 6;
   localparam int MU_W       = 41;
   localparam int MOM_W      = 47;
   localparam int J1_W       = 49;
   localparam int OUT_W      = 64;
   localparam int OP_W       = 64;
   localparam int WIDE_W     = 128;
   localparam int IDX_W      = 3;
   localparam int CNT_DIV_W  = 7;
   localparam int NORM_SHIFT = 28;
   localparam int ROOT_SHIFT = 60;
   localparam int J2_SHIFT   = 24;
   localparam int J3_SHIFT   = 48;
   localparam int MU_LIM_W   = 40;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(5);
   localparam logic [BIT_W-1:0] ROOT_TOP = BIT_W'(ROOT_W - 1);

   typedef enum logic [2:0] {
      TERM_CUBE = 3'd0,
      TERM_NSQH = 3'd1,
      TERM_NS   = 3'd2,
      TERM_SS   = 3'd3,
      TERM_J2   = 3'd4,
      TERM_J3   = 3'd5
   } term_type;

   typedef struct packed {
      logic             accum;
      logic             clear;
      logic             nsq_load;
      logic             mul_start;
      logic             root_upd;
      logic             d_load;
      logic             acc_clr;
      logic             acc_add;
      logic             div_start;
      logic             mu_load;
      logic             j2_load;
      logic             j3_load;
      logic             out_load;
      term_type         term;
      logic [IDX_W-1:0] idx;
      logic [BIT_W-1:0] bit_pos;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

// ----- sv/psmi_mul.sv -----
// ----------------------------------------------------------------------------
// psmi_mul
// Shift-add multiplier for the product of three magnitudes, one multiplier
// bit per cycle, stopping early once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module psmi_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [psmi_pkg::OP_W-1:0]     op_a,
   input  wire logic [psmi_pkg::OP_W-1:0]     op_b,
   input  wire logic [psmi_pkg::OP_W-1:0]     op_c,
   output logic                               done,
   output logic [psmi_pkg::WIDE_W-1:0]        prod
);
   import psmi_pkg::*;

   logic              busy_ff, busy_in;
   logic              phase_ff, phase_in;
   logic              done_ff, done_in;
   logic [WIDE_W-1:0] mcand_ff, mcand_in;
   logic [WIDE_W-1:0] prod_ff, prod_in;
   logic [OP_W-1:0]   mplier_ff, mplier_in;
   logic [OP_W-1:0]   c_ff, c_in;

   always_comb begin
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      done_in   = 1'b0;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      mplier_in = mplier_ff;
      c_in      = c_ff;
      if (start) begin
         busy_in   = 1'b1;
         phase_in  = 1'b0;
         mcand_in  = WIDE_W'(op_a);
         mplier_in = op_b;
         c_in      = op_c;
         prod_in   = '0;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            if (!phase_ff) begin
               // second pass multiplies the partial product by the third operand
               phase_in  = 1'b1;
               mcand_in  = prod_ff;
               mplier_in = c_ff;
               prod_in   = '0;
            end else begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[WIDE_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[OP_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff  <= phase_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      mplier_ff <= mplier_in;
      c_ff      <= c_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- sv/psmi_div.sv -----
// ----------------------------------------------------------------------------
// psmi_div
// Restoring divider, one quotient bit per cycle over the full word.
// ----------------------------------------------------------------------------
`default_nettype none

module psmi_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [psmi_pkg::WIDE_W-1:0]   num,
   input  wire logic [psmi_pkg::WIDE_W-1:0]   den,
   output logic                               done,
   output logic [psmi_pkg::WIDE_W-1:0]        quo
);
   import psmi_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_DIV_W-1:0] cnt_ff, cnt_in;
   logic [WIDE_W-1:0]    num_ff, num_in;
   logic [WIDE_W-1:0]    den_ff, den_in;
   logic [WIDE_W:0]      rem_ff, rem_in;
   logic [WIDE_W-1:0]    quo_ff, quo_in;
   logic [WIDE_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff[WIDE_W-1:0], num_ff[WIDE_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[WIDE_W-2:0], 1'b0};
         end
         num_in = {num_ff[WIDE_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_DIV_W'(1);
         if (cnt_ff == CNT_DIV_W'(WIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ----- sv/psmi_datapath.sv -----
// ----------------------------------------------------------------------------
// psmi_datapath
// Accumulators, cube root, central moments, normalization, invariants and
// the result register, driven step by step by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module psmi_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire psmi_pkg::cmd_type                     cmd,
   output psmi_pkg::status_type                       status,
   input  wire logic signed [psmi_pkg::COORD_W-1:0]   coord_x,
   input  wire logic signed [psmi_pkg::COORD_W-1:0]   coord_y,
   input  wire logic signed [psmi_pkg::COORD_W-1:0]   coord_z,
   output logic [psmi_pkg::MOM_W-1:0]                 moment_xx,
   output logic [psmi_pkg::MOM_W-1:0]                 moment_yy,
   output logic [psmi_pkg::MOM_W-1:0]                 moment_zz,
   output logic [psmi_pkg::J1_W-1:0]                  invariant_one,
   output logic signed [psmi_pkg::OUT_W-1:0]          invariant_two,
   output logic signed [psmi_pkg::OUT_W-1:0]          invariant_three,
   output logic [psmi_pkg::CNT_W-1:0]                 points_used
);
   import psmi_pkg::*;

   logic        [CNT_W-1:0]  n_ff;
   logic signed [S1_W-1:0]   s1_ff [3];
   logic signed [S2_W-1:0]   s2_ff [6];
   logic        [NSQ_W-1:0]  nsq_ff;
   logic        [ROOT_W-1:0] y_ff;
   logic        [WIDE_W-1:0] d_ff;
   logic        [WIDE_W-1:0] acc_ff;
   logic                     neg_ff;
   logic                     term_neg_ff;
   logic signed [MU_W-1:0]   mu_ff [6];
   logic signed [OUT_W-1:0]  j2_ff, j3_ff;

   logic [MOM_W-1:0]         mxx_ff, myy_ff, mzz_ff;
   logic [J1_W-1:0]          j1_ff;
   logic signed [OUT_W-1:0]  ot2_ff, ot3_ff;
   logic [CNT_W-1:0]         pts_ff;

   logic [CNT_W-1:0]         n_eff;
   logic [ROOT_W-1:0]        t_val;
   logic [OP_W-1:0]          op_a, op_b, op_c;
   logic                     term_neg;
   logic signed [S2_W-1:0]   s2_sel;
   logic signed [S1_W-1:0]   sa_sel, sb_sel;
   logic signed [MU_W-1:0]   ma_sel, mb_sel, mc_sel;
   logic                     sub_term;
   logic                     mul_done, div_done;
   logic [WIDE_W-1:0]        prod, quo;
   logic [WIDE_W-1:0]        acc_mag, div_num;
   logic [MU_LIM_W-1:0]      mu_val;
   logic [WIDE_W-1:0]        root_arg;
   logic signed [2*COORD_W-1:0] pr [6];

   function automatic logic [OP_W-1:0] mag_s2(input logic signed [S2_W-1:0] v);
      logic [S2_W-1:0] m;
      m = v[S2_W-1] ? S2_W'(-v) : S2_W'(v);
      return OP_W'(m);
   endfunction

   function automatic logic [OP_W-1:0] mag_s1(input logic signed [S1_W-1:0] v);
      logic [S1_W-1:0] m;
      m = v[S1_W-1] ? S1_W'(-v) : S1_W'(v);
      return OP_W'(m);
   endfunction

   function automatic logic [OP_W-1:0] mag_mu(input logic signed [MU_W-1:0] v);
      logic [MU_W-1:0] m;
      m = v[MU_W-1] ? MU_W'(-v) : MU_W'(v);
      return OP_W'(m);
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_shift(input logic [WIDE_W-1:0] v,
                                                         input int sh);
      logic signed [WIDE_W-1:0] s;
      s = $signed(v) >>> sh;
      if (s[WIDE_W-1:OUT_W-1] == '0 || s[WIDE_W-1:OUT_W-1] == '1) begin
         return s[OUT_W-1:0];
      end else if (s[WIDE_W-1]) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   assign n_eff    = (n_ff == '0) ? CNT_W'(1) : n_ff;
   assign t_val    = y_ff | (ROOT_W'(1) << cmd.bit_pos);
   assign root_arg = {{(WIDE_W-NSQ_W-ROOT_SHIFT){1'b0}}, nsq_ff, {ROOT_SHIFT{1'b0}}};

   // operand selection for the central sums and the invariant terms
   always_comb begin
      s2_sel   = s2_ff[0];
      sa_sel   = s1_ff[0];
      sb_sel   = s1_ff[0];
      ma_sel   = mu_ff[0];
      mb_sel   = mu_ff[1];
      mc_sel   = mu_ff[2];
      sub_term = 1'b0;
      unique case (cmd.idx)
         3'd0: begin
            s2_sel = s2_ff[0]; sa_sel = s1_ff[0]; sb_sel = s1_ff[0];
         end
         3'd1: begin
            s2_sel = s2_ff[1]; sa_sel = s1_ff[1]; sb_sel = s1_ff[1];
         end
         3'd2: begin
            s2_sel = s2_ff[2]; sa_sel = s1_ff[2]; sb_sel = s1_ff[2];
         end
         3'd3: begin
            s2_sel = s2_ff[3]; sa_sel = s1_ff[0]; sb_sel = s1_ff[1];
         end
         3'd4: begin
            s2_sel = s2_ff[4]; sa_sel = s1_ff[0]; sb_sel = s1_ff[2];
         end
         3'd5: begin
            s2_sel = s2_ff[5]; sa_sel = s1_ff[1]; sb_sel = s1_ff[2];
         end
         default: begin
            s2_sel = s2_ff[0];
         end
      endcase
      if (cmd.term == TERM_J2) begin
         mc_sel = MU_W'(1);
         unique case (cmd.idx)
            3'd0: begin ma_sel = mu_ff[0]; mb_sel = mu_ff[1]; end
            3'd1: begin ma_sel = mu_ff[0]; mb_sel = mu_ff[2]; end
            3'd2: begin ma_sel = mu_ff[1]; mb_sel = mu_ff[2]; end
            3'd3: begin ma_sel = mu_ff[3]; mb_sel = mu_ff[3]; sub_term = 1'b1; end
            3'd4: begin ma_sel = mu_ff[4]; mb_sel = mu_ff[4]; sub_term = 1'b1; end
            3'd5: begin ma_sel = mu_ff[5]; mb_sel = mu_ff[5]; sub_term = 1'b1; end
            default: begin ma_sel = mu_ff[0]; end
         endcase
      end else begin
         unique case (cmd.idx)
            3'd0: begin
               ma_sel = mu_ff[0]; mb_sel = mu_ff[1]; mc_sel = mu_ff[2];
            end
            3'd1, 3'd2: begin
               ma_sel = mu_ff[3]; mb_sel = mu_ff[4]; mc_sel = mu_ff[5];
            end
            3'd3: begin
               ma_sel = mu_ff[2]; mb_sel = mu_ff[3]; mc_sel = mu_ff[3]; sub_term = 1'b1;
            end
            3'd4: begin
               ma_sel = mu_ff[1]; mb_sel = mu_ff[4]; mc_sel = mu_ff[4]; sub_term = 1'b1;
            end
            3'd5: begin
               ma_sel = mu_ff[0]; mb_sel = mu_ff[5]; mc_sel = mu_ff[5]; sub_term = 1'b1;
            end
            default: begin ma_sel = mu_ff[0]; end
         endcase
      end
   end

   always_comb begin
      op_a     = '0;
      op_b     = '0;
      op_c     = OP_W'(1);
      term_neg = 1'b0;
      unique case (cmd.term)
         TERM_CUBE: begin
            op_a = OP_W'(t_val); op_b = OP_W'(t_val); op_c = OP_W'(t_val);
         end
         TERM_NSQH: begin
            op_a = OP_W'(nsq_ff); op_b = OP_W'(y_ff);
         end
         TERM_NS: begin
            op_a     = OP_W'(n_eff);
            op_b     = mag_s2(s2_sel);
            term_neg = s2_sel[S2_W-1];
         end
         TERM_SS: begin
            // product of sums is subtracted
            op_a     = mag_s1(sa_sel);
            op_b     = mag_s1(sb_sel);
            term_neg = ~(sa_sel[S1_W-1] ^ sb_sel[S1_W-1]);
         end
         TERM_J2, TERM_J3: begin
            op_a     = mag_mu(ma_sel);
            op_b     = mag_mu(mb_sel);
            op_c     = mag_mu(mc_sel);
            term_neg = ma_sel[MU_W-1] ^ mb_sel[MU_W-1] ^ mc_sel[MU_W-1] ^ sub_term;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   psmi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .op_a  (op_a),
      .op_b  (op_b),
      .op_c  (op_c),
      .done  (mul_done),
      .prod  (prod)
   );

   assign acc_mag = acc_ff[WIDE_W-1] ? (~acc_ff + WIDE_W'(1)) : acc_ff;
   assign div_num = acc_mag << NORM_SHIFT;

   psmi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (d_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign mu_val = (quo[WIDE_W-1:MU_LIM_W] != '0) ? '1 : quo[MU_LIM_W-1:0];

   assign pr[0] = coord_x * coord_x;
   assign pr[1] = coord_y * coord_y;
   assign pr[2] = coord_z * coord_z;
   assign pr[3] = coord_x * coord_y;
   assign pr[4] = coord_x * coord_z;
   assign pr[5] = coord_y * coord_z;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         n_ff <= '0;
         for (int i = 0; i < 3; i++) s1_ff[i] <= '0;
         for (int i = 0; i < 6; i++) s2_ff[i] <= '0;
      end else if (cmd.accum && n_ff < CNT_W'(MAX_POINTS)) begin
         n_ff     <= n_ff + CNT_W'(1);
         s1_ff[0] <= s1_ff[0] + S1_W'(coord_x);
         s1_ff[1] <= s1_ff[1] + S1_W'(coord_y);
         s1_ff[2] <= s1_ff[2] + S1_W'(coord_z);
         for (int i = 0; i < 6; i++) s2_ff[i] <= s2_ff[i] + S2_W'(pr[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nsq_load) begin
         nsq_ff <= NSQ_W'(n_eff) * NSQ_W'(n_eff);
         y_ff   <= '0;
      end else if (cmd.root_upd && root_arg >= prod) begin
         y_ff <= t_val;
      end
      if (cmd.d_load) begin
         d_ff <= prod;
      end
      if (cmd.mul_start) begin
         term_neg_ff <= term_neg;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= term_neg_ff ? acc_ff - prod : acc_ff + prod;
      end
      if (cmd.div_start) begin
         neg_ff <= acc_ff[WIDE_W-1];
      end
      if (cmd.mu_load) begin
         mu_ff[cmd.idx] <= neg_ff ? -$signed({1'b0, mu_val}) : $signed({1'b0, mu_val});
      end
      if (cmd.j2_load) begin
         j2_ff <= sat_shift(acc_ff, J2_SHIFT);
      end
      if (cmd.j3_load) begin
         j3_ff <= sat_shift(acc_ff, J3_SHIFT);
      end
      if (cmd.out_load) begin
         mxx_ff <= mu_ff[0][MU_W-1] ? '0 : MOM_W'(mu_ff[0]);
         myy_ff <= mu_ff[1][MU_W-1] ? '0 : MOM_W'(mu_ff[1]);
         mzz_ff <= mu_ff[2][MU_W-1] ? '0 : MOM_W'(mu_ff[2]);
         j1_ff  <= (mu_ff[0][MU_W-1] ? '0 : J1_W'(mu_ff[0]))
                 + (mu_ff[1][MU_W-1] ? '0 : J1_W'(mu_ff[1]))
                 + (mu_ff[2][MU_W-1] ? '0 : J1_W'(mu_ff[2]));
         ot2_ff <= j2_ff;
         ot3_ff <= j3_ff;
         pts_ff <= n_ff;
      end
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;

   assign moment_xx       = mxx_ff;
   assign moment_yy       = myy_ff;
   assign moment_zz       = mzz_ff;
   assign invariant_one   = j1_ff;
   assign invariant_two   = ot2_ff;
   assign invariant_three = ot3_ff;
   assign points_used     = pts_ff;

endmodule

`default_nettype wire

// ----- sv/psmi_ctrl.sv -----
// ----------------------------------------------------------------------------
// psmi_ctrl
// Sequencer: accepts points, then steps the datapath through the cube root,
// the six central moments, the invariants and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module psmi_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_last_point,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output psmi_pkg::cmd_type          cmd,
   input  wire psmi_pkg::status_type  status
);
   import psmi_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE   = 19'b0000000000000000001,
      S_NSQ    = 19'b0000000000000000010,
      S_ROOT   = 19'b0000000000000000100,
      S_ROOT_W = 19'b0000000000000001000,
      S_DMUL   = 19'b0000000000000010000,
      S_DMUL_W = 19'b0000000000000100000,
      S_CA     = 19'b0000000000001000000,
      S_CA_W   = 19'b0000000000010000000,
      S_CB     = 19'b0000000000100000000,
      S_CB_W   = 19'b0000000001000000000,
      S_DIV    = 19'b0000000010000000000,
      S_DIV_W  = 19'b0000000100000000000,
      S_J2     = 19'b0000001000000000000,
      S_J2_W   = 19'b0000010000000000000,
      S_J2_END = 19'b0000100000000000000,
      S_J3     = 19'b0001000000000000000,
      S_J3_W   = 19'b0010000000000000000,
      S_J3_END = 19'b0100000000000000000,
      S_OUT    = 19'b1000000000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.term     = TERM_CUBE;
      cmd.idx      = idx_ff;
      cmd.bit_pos  = bit_ff;
      cmd.accum    = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_last_point) begin
               state_in = S_NSQ;
            end
         end
         S_NSQ: begin
            cmd.nsq_load = 1'b1;
            bit_in       = ROOT_TOP;
            state_in     = S_ROOT;
         end
         S_ROOT: begin
            cmd.mul_start = 1'b1;
            state_in      = S_ROOT_W;
         end
         S_ROOT_W: begin
            if (status.mul_done) begin
               cmd.root_upd = 1'b1;
               if (bit_ff == '0) begin
                  state_in = S_DMUL;
               end else begin
                  bit_in   = bit_ff - BIT_W'(1);
                  state_in = S_ROOT;
               end
            end
         end
         S_DMUL: begin
            cmd.term      = TERM_NSQH;
            cmd.mul_start = 1'b1;
            state_in      = S_DMUL_W;
         end
         S_DMUL_W: begin
            if (status.mul_done) begin
               cmd.d_load = 1'b1;
               idx_in     = '0;
               state_in   = S_CA;
            end
         end
         S_CA: begin
            cmd.term      = TERM_NS;
            cmd.acc_clr   = 1'b1;
            cmd.mul_start = 1'b1;
            state_in      = S_CA_W;
         end
         S_CA_W: begin
            if (status.mul_done) begin
               cmd.acc_add = 1'b1;
               state_in    = S_CB;
            end
         end
         S_CB: begin
            cmd.term      = TERM_SS;
            cmd.mul_start = 1'b1;
            state_in      = S_CB_W;
         end
         S_CB_W: begin
            if (status.mul_done) begin
               cmd.acc_add = 1'b1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_W;
         end
         S_DIV_W: begin
            if (status.div_done) begin
               cmd.mu_load = 1'b1;
               if (idx_ff == IDX_LAST) begin
                  cmd.acc_clr = 1'b1;
                  idx_in      = '0;
                  state_in    = S_J2;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_CA;
               end
            end
         end
         S_J2: begin
            cmd.term      = TERM_J2;
            cmd.mul_start = 1'b1;
            state_in      = S_J2_W;
         end
         S_J2_W: begin
            cmd.term = TERM_J2;
            if (status.mul_done) begin
               cmd.acc_add = 1'b1;
               if (idx_ff == IDX_LAST) begin
                  state_in = S_J2_END;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_J2;
               end
            end
         end
         S_J2_END: begin
            cmd.j2_load = 1'b1;
            cmd.acc_clr = 1'b1;
            idx_in      = '0;
            state_in    = S_J3;
         end
         S_J3: begin
            cmd.term      = TERM_J3;
            cmd.mul_start = 1'b1;
            state_in      = S_J3_W;
         end
         S_J3_W: begin
            cmd.term = TERM_J3;
            if (status.mul_done) begin
               cmd.acc_add = 1'b1;
               if (idx_ff == IDX_LAST) begin
                  state_in = S_J3_END;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_J3;
               end
            end
         end
         S_J3_END: begin
            cmd.j3_load = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // wait for the result register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- sv/point_set_moment_invariants_3d_core.sv -----
// ----------------------------------------------------------------------------
// point_set_moment_invariants_3d_core
// Second-order 3D moment invariants of a streamed point set.
// ----------------------------------------------------------------------------
// Input channel req_*: one Q11.4 point per item, req_last_point closes the set.
// Points that do not close a set are taken one per cycle; while the set holds
// fewer than 65536 points, each one updates the count, the coordinate sums and
// the six product sums as it is accepted. The closing point starts the
// finishing sequence, during which req_ready is low. It runs on one shift-add
// multiplier (one multiplier bit per cycle) and one restoring divider: 38
// cube-root trials, the denominator, six central moments each with two
// products and a division, and twelve invariant terms.
// Output channel rsp_*: one result item per set, held in a result register
// until taken. While it waits, the next set is accepted; if a further set is
// finished before the result is taken, the block holds in its last step and
// keeps req_ready low until rsp_ready frees the register.
// Reset clears the count, the sums and all control state; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module point_set_moment_invariants_3d_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [psmi_pkg::COORD_W-1:0]   req_coord_x,
   input  wire logic signed [psmi_pkg::COORD_W-1:0]   req_coord_y,
   input  wire logic signed [psmi_pkg::COORD_W-1:0]   req_coord_z,
   input  wire logic                                  req_last_point,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [psmi_pkg::MOM_W-1:0]                 rsp_moment_xx,
   output logic [psmi_pkg::MOM_W-1:0]                 rsp_moment_yy,
   output logic [psmi_pkg::MOM_W-1:0]                 rsp_moment_zz,
   output logic [psmi_pkg::J1_W-1:0]                  rsp_invariant_one,
   output logic signed [psmi_pkg::OUT_W-1:0]          rsp_invariant_two,
   output logic signed [psmi_pkg::OUT_W-1:0]          rsp_invariant_three,
   output logic [psmi_pkg::CNT_W-1:0]                 rsp_points_used
);
   import psmi_pkg::*;

   cmd_type    cmd;
   status_type status;

   psmi_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd),
      .status         (status)
   );

   psmi_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .coord_x         (req_coord_x),
      .coord_y         (req_coord_y),
      .coord_z         (req_coord_z),
      .moment_xx       (rsp_moment_xx),
      .moment_yy       (rsp_moment_yy),
      .moment_zz       (rsp_moment_zz),
      .invariant_one   (rsp_invariant_one),
      .invariant_two   (rsp_invariant_two),
      .invariant_three (rsp_invariant_three),
      .points_used     (rsp_points_used)
   );

endmodule

`default_nettype wire

// ----- test/tb_point_set_moment_invariants_3d_core.sv -----
// ----------------------------------------------------------------------------
// tb_point_set_moment_invariants_3d_core
// Streams point sets into the moment invariant core and checks every result
// item, field by field, against a bit-accurate predictor of the moments and
// invariants. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_set_moment_invariants_3d_core;
   timeunit 1ns;
   timeprecision 1ps;
   import psmi_pkg::*;

   localparam int  WATCHDOG_LIMIT = 100000;
   localparam int  LONG_HOLD      = 20000;
   localparam int  RANDOM_ITEMS   = 1880;

   typedef struct {
      logic [MOM_W-1:0]        mxx, myy, mzz;
      logic [J1_W-1:0]         j1;
      logic signed [OUT_W-1:0] j2, j3;
      logic [CNT_W-1:0]        used;
   } moments_type;

   class moment_scoreboard;
      moments_type expected_q[$];
      longint      count;
      longint      sum1[3];
      longint      sum2[6];
      int          errors;
      int          sets_checked;

      function new();
         count = 0; errors = 0; sets_checked = 0;
         foreach (sum1[i]) sum1[i] = 0;
         foreach (sum2[i]) sum2[i] = 0;
      endfunction

      task report(string what, logic [127:0] got, logic [127:0] want);
         $display("mismatch on %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      function logic [63:0] cube_root(logic [63:0] nsq);
         logic [127:0] arg, t;
         logic [63:0]  y;
         arg = {64'd0, nsq} << ROOT_SHIFT;
         y = 0;
         for (int b = ROOT_W - 1; b >= 0; b--) begin
            t = {64'd0, y | (64'd1 << b)};
            if (arg >= t * t * t) y = y | (64'd1 << b);
         end
         return y;
      endfunction

      function logic signed [63:0] sat(logic signed [127:0] v);
         if (v > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
         if (v < -128'sh8000000000000000) return 64'sh8000000000000000;
         return v[63:0];
      endfunction

      function moments_type finish_set();
         int pa[6] = '{0, 1, 2, 0, 0, 1};
         int pb[6] = '{0, 1, 2, 1, 2, 2};
         moments_type r;
         logic [63:0] n, nsq, h;
         logic signed [127:0] c, w, j2, j3;
         logic [127:0] m, q;
         logic signed [127:0] mu[6];
         n = (count == 0) ? 1 : count;
         nsq = n * n;
         h = cube_root(nsq);
         for (int i = 0; i < 6; i++) begin
            c = $signed({64'd0, n});
            c = c * sum2[i];
            w = sum1[pa[i]];
            w = w * sum1[pb[i]];
            c = c - w;
            m = (c < 0) ? -c : c;
            q = (m << NORM_SHIFT) / ({64'd0, nsq} * {64'd0, h});
            if (q > (128'd1 << MU_LIM_W) - 1) q = (128'd1 << MU_LIM_W) - 1;
            mu[i] = (c < 0) ? -$signed(q) : $signed(q);
         end
         j2 = mu[0] * mu[1] + mu[0] * mu[2] + mu[1] * mu[2]
              - mu[3] * mu[3] - mu[4] * mu[4] - mu[5] * mu[5];
         j3 = mu[0] * mu[1] * mu[2] + 2 * mu[3] * mu[4] * mu[5]
              - mu[2] * mu[3] * mu[3] - mu[1] * mu[4] * mu[4] - mu[0] * mu[5] * mu[5];
         // diagonal moments cannot exceed 2^40, so clamping to 47 bits is moot
         r.mxx = (mu[0] < 0) ? '0 : mu[0][MOM_W-1:0];
         r.myy = (mu[1] < 0) ? '0 : mu[1][MOM_W-1:0];
         r.mzz = (mu[2] < 0) ? '0 : mu[2][MOM_W-1:0];
         r.j1 = J1_W'(r.mxx) + J1_W'(r.myy) + J1_W'(r.mzz);
         r.j2 = sat(j2 >>> J2_SHIFT);
         r.j3 = sat(j3 >>> J3_SHIFT);
         r.used = count[CNT_W-1:0];
         return r;
      endfunction

      function void note_point(logic signed [15:0] x, y, z, logic last);
         longint p[3];
         int pa[6] = '{0, 1, 2, 0, 0, 1};
         int pb[6] = '{0, 1, 2, 1, 2, 2};
         p[0] = x; p[1] = y; p[2] = z;
         // a full set ignores further points but still honours the last flag
         if (count < MAX_POINTS) begin
            count++;
            for (int i = 0; i < 3; i++) sum1[i] += p[i];
            for (int i = 0; i < 6; i++) sum2[i] += p[pa[i]] * p[pb[i]];
         end
         if (last) begin
            expected_q.push_back(finish_set());
            count = 0;
            foreach (sum1[i]) sum1[i] = 0;
            foreach (sum2[i]) sum2[i] = 0;
         end
      endfunction

      task check_result(moments_type got);
         moments_type e;
         if (expected_q.size() == 0) begin
            $display("result item with no set outstanding");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         sets_checked++;
         if (got.mxx !== e.mxx) report("moment_xx", got.mxx, e.mxx);
         if (got.myy !== e.myy) report("moment_yy", got.myy, e.myy);
         if (got.mzz !== e.mzz) report("moment_zz", got.mzz, e.mzz);
         if (got.j1 !== e.j1) report("invariant_one", got.j1, e.j1);
         if (got.j2 !== e.j2) report("invariant_two", got.j2, e.j2);
         if (got.j3 !== e.j3) report("invariant_three", got.j3, e.j3);
         if (got.used !== e.used) report("points_used", got.used, e.used);
      endtask
   endclass

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_ready;
   logic signed [COORD_W-1:0] req_coord_x = 0, req_coord_y = 0, req_coord_z = 0;
   logic                    req_last_point = 0;
   logic                    rsp_valid;
   logic                    rsp_ready = 0;
   logic [MOM_W-1:0]        rsp_moment_xx, rsp_moment_yy, rsp_moment_zz;
   logic [J1_W-1:0]         rsp_invariant_one;
   logic signed [OUT_W-1:0] rsp_invariant_two, rsp_invariant_three;
   logic [CNT_W-1:0]        rsp_points_used;

   moment_scoreboard sb = new();
   bit   hold_output = 0;
   bit   no_idle     = 0;
   int   items_sent  = 0;
   int   idle_cycles = 0;

   always #6 clock = ~clock;

   point_set_moment_invariants_3d_core u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_coord_x, .req_coord_y,
      .req_coord_z, .req_last_point, .rsp_valid, .rsp_ready, .rsp_moment_xx,
      .rsp_moment_yy, .rsp_moment_zz, .rsp_invariant_one, .rsp_invariant_two,
      .rsp_invariant_three, .rsp_points_used
   );

   function int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 200);
   endfunction

   function logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3, 4: return 16'($signed($urandom_range(0, 200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   // called just after a rising edge; returns just after the accepting edge
   task send_point(logic [15:0] x, y, z, logic last);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid      <= 1;
      req_coord_x    <= x;
      req_coord_y    <= y;
      req_coord_z    <= z;
      req_last_point <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task send_random_set(int size);
      for (int i = 0; i < size; i++)
         send_point(pick_coord(), pick_coord(), pick_coord(), i == size - 1);
   endtask

   // one edge first so the last accepted item has reached the scoreboard
   task wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // accepted items on both channels, sampled at the edge
   always @(posedge clock) begin
      moments_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_point(req_coord_x, req_coord_y, req_coord_z, req_last_point);
         if (rsp_valid && rsp_ready) begin
            got.mxx = rsp_moment_xx; got.myy = rsp_moment_yy; got.mzz = rsp_moment_zz;
            got.j1 = rsp_invariant_one; got.j2 = rsp_invariant_two;
            got.j3 = rsp_invariant_three; got.used = rsp_points_used;
            sb.check_result(got);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // receiver side
   initial begin
      int g;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_ready <= 0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_output = 0;
         end else if (no_idle) begin
            rsp_ready <= 1;
            @(posedge clock);
         end else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_ready <= 0;
               repeat (g) @(posedge clock);
            end
            rsp_ready <= 1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      int size;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: lone points at the extremes, cancelling sums, a flat set
      send_point(16'h8000, 16'h8000, 16'h8000, 1);
      send_point(16'h7FFF, 16'h8000, 16'h0000, 1);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send_point(16'h8000, 16'h8000, 16'h8000, 1);
      send_point(16'h7FFF, 16'h8000, 16'h7FFF, 0);
      send_point(16'h8000, 16'h7FFF, 16'h8000, 1);
      send_point(16'h0000, 16'h0000, 16'h0000, 0);
      send_point(16'h0000, 16'h0000, 16'h0000, 1);
      send_point(16'h0010, 16'h0000, 16'h0000, 0);
      send_point(16'h0000, 16'h0010, 16'h0000, 0);
      send_point(16'h0000, 16'h0000, 16'h0010, 0);
      send_point(16'hFFF0, 16'hFFF0, 16'hFFF0, 1);
      send_point(16'h7FFF, 16'h7FFF, 16'h8000, 0);
      send_point(16'h8000, 16'h8000, 16'h7FFF, 0);
      send_point(16'h7FFF, 16'h7FFF, 16'h8000, 0);
      send_point(16'h8000, 16'h8000, 16'h7FFF, 1);
      wait_drained();

      // long receiver hold-off while sets keep coming, so the input stalls
      hold_output = 1;
      for (int s = 0; s < 4; s++) send_random_set($urandom_range(1, 6));
      wait_drained();

      // random sets, mostly short, a few long, some stretches without idling
      while (items_sent < 16 + RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 5) == 0);
         size = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 24);
         send_random_set(size);
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
      no_idle = 0;
      wait_drained();
      repeat (5000) @(posedge clock);

      $display("sent %0d points, checked %0d result sets", items_sent, sb.sets_checked);
      $display("covered extreme coordinates, single-point sets and a long output stall");
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
